// ===== rtl/icrt_pkg.sv =====
// Package for the id compaction remap table: payload types, command codes and widths.
// Has no dependencies. Every other file but icrt_g2l_mem imports it.
`default_nettype none
package icrt_pkg;

    localparam int ID_W    = 12;
    localparam int CNT_W   = 13;
    localparam int EPOCH_W = 8;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic            batch_end;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]  first_value;
        logic [ID_W-1:0]  second_value;
        logic             first_found;
        logic             second_found;
        logic             newly_added;
        logic             index_error;
        logic [CNT_W-1:0] item_count;
        logic             batch_done;
    } t_out;

endpackage
`default_nettype wire

// ===== rtl/icrt_g2l_mem.sv =====
// Global-to-local table memory: one write port and two registered read ports.
// Depends on nothing but its parameters.
`default_nettype none
module icrt_g2l_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr1,
    input  wire logic [AW-1:0] i_raddr2,
    output logic      [DW-1:0] o_rdata1,
    output logic      [DW-1:0] o_rdata2
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd1;
    logic [DW-1:0] r_rd2;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd1 <= r_mem[i_raddr1];
            r_rd2 <= r_mem[i_raddr2];
        end
    end

    assign o_rdata1 = r_rd1;
    assign o_rdata2 = r_rd2;

endmodule
`default_nettype wire

// ===== rtl/icrt_l2g_mem.sv =====
// Local-to-global table memory: one write port and one registered read port.
// Depends on icrt_pkg for the id width.
`default_nettype none
module icrt_l2g_mem
    import icrt_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire logic [ID_W-1:0] i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output logic      [ID_W-1:0] o_rdata
);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd;

endmodule
`default_nettype wire

// ===== rtl/id_compaction_remap_table.sv =====
// Top level of the id compaction remap table; control, forwarding and output register.
// Depends on icrt_pkg, icrt_g2l_mem and icrt_l2g_mem.
//
// The block relabels global ids to dense local ids in first-seen order and answers
// insert, edge map, node read and clear commands with one result each. An accepted
// item reads the memories as it is taken into the s1 register, and its result is
// then registered in the output register, which offers it. One item per cycle is
// sustained while results are taken; the single memory read per item sets that
// figure. Validity is kept as an epoch tag stored with each entry, so a clear only
// advances the tag. After reset, and after every 255th clear when the epoch tag
// wraps, a pass rewrites all min(CAPACITY, 4096) entries of the global-to-local
// memory, one per cycle, during which no input is accepted.
`default_nettype none
module id_compaction_remap_table
    import icrt_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int DEPTH = (CAPACITY < (1 << ID_W)) ? CAPACITY : (1 << ID_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = EPOCH_W + AW;
    localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    logic                r_s1_v;
    t_in                 r_s1;
    logic                r_out_v;
    t_out                r_out;
    logic [CNT_W-1:0]    r_count;
    logic [EPOCH_W-1:0]  r_epoch;
    logic                r_sweep;
    logic [AW-1:0]       r_sweep_addr;
    logic                r_fwd_v;
    logic [ID_W-1:0]     r_fwd_id;
    logic [ID_W-1:0]     r_fwd_local;

    t_out                n_res;
    logic [CNT_W-1:0]    n_count;
    logic                ins_new;
    logic                is_clear;

    logic [EW-1:0]       g2l_rd1;
    logic [EW-1:0]       g2l_rd2;
    logic [ID_W-1:0]     l2g_rd;
    logic                g2l_we;
    logic [AW-1:0]       g2l_waddr;
    logic [EW-1:0]       g2l_wdata;

    logic in_fire;
    logic s1_fire;
    logic wrap_clear;
    logic a_in;
    logic b_in;
    logic fwd_a;
    logic fwd_b;
    logic hit_a;
    logic hit_b;
    logic [ID_W-1:0] loc_a;
    logic [ID_W-1:0] loc_b;

    assign in_fire    = i_in_valid && o_in_ready;
    assign s1_fire    = r_s1_v && (!r_out_v || i_out_ready);
    assign wrap_clear = r_s1_v && (r_s1.cmd == CMD_CLEAR) && (r_epoch == EPOCH_MAX);
    assign o_in_ready = !r_sweep && (!r_s1_v || s1_fire) && !wrap_clear;

    assign a_in  = {1'b0, r_s1.first_id} < DEPTH_C;
    assign b_in  = {1'b0, r_s1.second_id} < DEPTH_C;
    assign fwd_a = r_fwd_v && (r_fwd_id == r_s1.first_id);
    assign fwd_b = r_fwd_v && (r_fwd_id == r_s1.second_id);
    assign hit_a = a_in && (fwd_a || (g2l_rd1[EW-1:AW] == r_epoch));
    assign hit_b = b_in && (fwd_b || (g2l_rd2[EW-1:AW] == r_epoch));
    assign loc_a = fwd_a ? r_fwd_local : ID_W'(g2l_rd1[AW-1:0]);
    assign loc_b = fwd_b ? r_fwd_local : ID_W'(g2l_rd2[AW-1:0]);

    always_comb begin
        n_res    = '0;
        n_count  = r_count;
        ins_new  = 1'b0;
        is_clear = 1'b0;
        case (r_s1.cmd)
            CMD_INSERT: begin
                if (hit_a) begin
                    n_res.first_value = loc_a;
                    n_res.first_found = 1'b1;
                end else if (a_in && (r_count < DEPTH_C)) begin
                    ins_new           = 1'b1;
                    n_res.first_value = r_count[ID_W-1:0];
                    n_res.newly_added = 1'b1;
                    n_count           = r_count + CNT_W'(1);
                end
            end
            CMD_EDGE: begin
                n_res.first_found  = hit_a;
                n_res.second_found = hit_b;
                n_res.first_value  = hit_a ? loc_a : '0;
                n_res.second_value = hit_b ? loc_b : '0;
            end
            CMD_READ: begin
                if ({1'b0, r_s1.first_id} < r_count) begin
                    n_res.first_found = 1'b1;
                    n_res.first_value = (r_fwd_v && (r_fwd_local == r_s1.first_id))
                                        ? r_fwd_id : l2g_rd;
                end else begin
                    n_res.index_error = 1'b1;
                end
            end
            CMD_CLEAR: begin
                is_clear = 1'b1;
                n_count  = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_res.item_count = n_count;
        n_res.batch_done = r_s1.batch_end;
    end

    assign g2l_we    = r_sweep || (s1_fire && ins_new);
    assign g2l_waddr = r_sweep ? r_sweep_addr : r_s1.first_id[AW-1:0];
    assign g2l_wdata = r_sweep ? '0 : {r_epoch, r_count[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v       <= 1'b0;
            r_out_v      <= 1'b0;
            r_count      <= '0;
            r_epoch      <= EPOCH_ONE;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_fwd_v      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (s1_fire) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == LAST_ADDR) begin
                    r_sweep <= 1'b0;
                end
            end
            if (s1_fire) begin
                r_count <= n_count;
                r_fwd_v <= ins_new;
                if (is_clear) begin
                    if (r_epoch == EPOCH_MAX) begin
                        r_epoch      <= EPOCH_ONE;
                        r_sweep      <= 1'b1;
                        r_sweep_addr <= '0;
                    end else begin
                        r_epoch <= r_epoch + EPOCH_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_data;
        end
        if (s1_fire) begin
            r_out <= n_res;
        end
        if (s1_fire && ins_new) begin
            r_fwd_id    <= r_s1.first_id;
            r_fwd_local <= r_count[ID_W-1:0];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    icrt_g2l_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_g2l_mem (
        .i_clk    (i_clk),
        .i_we     (g2l_we),
        .i_waddr  (g2l_waddr),
        .i_wdata  (g2l_wdata),
        .i_re     (in_fire),
        .i_raddr1 (i_in_data.first_id[AW-1:0]),
        .i_raddr2 (i_in_data.second_id[AW-1:0]),
        .o_rdata1 (g2l_rd1),
        .o_rdata2 (g2l_rd2)
    );

    icrt_l2g_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_l2g_mem (
        .i_clk   (i_clk),
        .i_we    (s1_fire && ins_new),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_s1.first_id),
        .i_re    (in_fire),
        .i_raddr (i_in_data.first_id[AW-1:0]),
        .o_rdata (l2g_rd)
    );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for id_compaction_remap_table: directed commands, a large table
// fill, and random traffic heavy in clears, each result checked against a predictor.
// Depends on icrt_pkg and the id_compaction_remap_table RTL.
module tb
    import icrt_pkg::*;
();

    localparam int ID_SPACE       = 1 << ID_W;
    localparam int FILL_ITEMS     = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PRINT_LIMIT    = 50;

    class remap_tracker;
        bit               mark [2**ID_W];
        logic [ID_W-1:0]  local_of [2**ID_W];
        logic [ID_W-1:0]  global_of [2**ID_W];
        logic [CNT_W-1:0] count;
        t_out             pending_results [$];
        int unsigned      results_seen;
        int unsigned      errors;

        function new();
            mark = '{default: 1'b0};
            count = '0;
            results_seen = 0;
            errors = 0;
        endfunction

        function t_out predict_reply(t_in item);
            t_out reply;
            reply = '0;
            case (item.cmd)
                CMD_INSERT: begin
                    if (mark[item.first_id]) begin
                        reply.first_value = local_of[item.first_id];
                        reply.first_found = 1'b1;
                    end else if (count < 2**ID_W) begin
                        mark[item.first_id] = 1'b1;
                        local_of[item.first_id] = count[ID_W-1:0];
                        global_of[count[ID_W-1:0]] = item.first_id;
                        reply.first_value = count[ID_W-1:0];
                        reply.newly_added = 1'b1;
                        count = count + 1'b1;
                    end
                end
                CMD_EDGE: begin
                    if (mark[item.first_id]) begin
                        reply.first_value = local_of[item.first_id];
                        reply.first_found = 1'b1;
                    end
                    if (mark[item.second_id]) begin
                        reply.second_value = local_of[item.second_id];
                        reply.second_found = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (item.first_id < count) begin
                        reply.first_value = global_of[item.first_id];
                        reply.first_found = 1'b1;
                    end else begin
                        reply.index_error = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    mark = '{default: 1'b0};
                    count = '0;
                end
                default: ;
            endcase
            reply.item_count = count;
            reply.batch_done = item.batch_end;
            return reply;
        endfunction

        function void note_input(t_in item);
            pending_results.push_back(predict_reply(item));
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h arrived with nothing expected", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.first_value !== want.first_value)
                report($sformatf("result %0d first_value %h, expected %h",
                                 results_seen, got.first_value, want.first_value));
            if (got.second_value !== want.second_value)
                report($sformatf("result %0d second_value %h, expected %h",
                                 results_seen, got.second_value, want.second_value));
            if (got.first_found !== want.first_found)
                report($sformatf("result %0d first_found %b, expected %b",
                                 results_seen, got.first_found, want.first_found));
            if (got.second_found !== want.second_found)
                report($sformatf("result %0d second_found %b, expected %b",
                                 results_seen, got.second_found, want.second_found));
            if (got.newly_added !== want.newly_added)
                report($sformatf("result %0d newly_added %b, expected %b",
                                 results_seen, got.newly_added, want.newly_added));
            if (got.index_error !== want.index_error)
                report($sformatf("result %0d index_error %b, expected %b",
                                 results_seen, got.index_error, want.index_error));
            if (got.item_count !== want.item_count)
                report($sformatf("result %0d item_count %0d, expected %0d",
                                 results_seen, got.item_count, want.item_count));
            if (got.batch_done !== want.batch_done)
                report($sformatf("result %0d batch_done %b, expected %b",
                                 results_seen, got.batch_done, want.batch_done));
            results_seen++;
        endtask
    endclass

    logic            clk;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    t_in             in_data = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    t_out            out_data;
    bit              no_idle = 1'b0;
    bit              hold_req = 1'b0;
    int unsigned     stall_cycles = 0;
    remap_tracker    tracker;
    logic [ID_W-1:0] seen_ids [$];
    bit              seen_mark [ID_SPACE];

    id_compaction_remap_table i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            tracker.note_input(in_data);
        end
        if (rst_n && out_valid && out_ready) begin
            tracker.check_result(out_data);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("id_compaction_remap_table verification failed");
            $finish;
        end
    end

    // A requested hold-off keeps ready low for a fixed stretch so the block backs up.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= no_idle || ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic send(t_in item);
        while (!no_idle && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic issue(logic [1:0] cmd, logic [ID_W-1:0] a, logic [ID_W-1:0] b, bit last);
        t_in item;
        item.cmd = cmd;
        item.first_id = a;
        item.second_id = b;
        item.batch_end = last;
        case (cmd)
            CMD_INSERT: begin
                if (!seen_mark[a]) begin
                    seen_mark[a] = 1'b1;
                    seen_ids.push_back(a);
                end
            end
            CMD_CLEAR: begin
                seen_mark = '{default: 1'b0};
                seen_ids.delete();
            end
            default: ;
        endcase
        send(item);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    function automatic logic [ID_W-1:0] pick_id(int unsigned base, int unsigned span);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50 && seen_ids.size() != 0) begin
            return seen_ids[$urandom_range(seen_ids.size() - 1)];
        end
        if (roll < 85) begin
            return ID_W'(base + $urandom_range(span - 1));
        end
        return ID_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] pick_index();
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99);
        span = seen_ids.size();
        if (roll < 85) begin
            return ID_W'($urandom_range(span));
        end
        if (roll < 95) begin
            return ID_W'(span + $urandom_range(3));
        end
        return ID_W'($urandom);
    endfunction

    task automatic run_segment(int unsigned len, int unsigned base, int unsigned span,
                               int unsigned clear_pct);
        int unsigned roll;
        for (int n = 0; n < len; n++) begin
            roll = $urandom_range(99);
            if (roll < clear_pct) begin
                issue(CMD_CLEAR, ID_W'($urandom), ID_W'($urandom), $urandom_range(7) == 0);
            end else begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    issue(CMD_INSERT, pick_id(base, span), ID_W'($urandom),
                          $urandom_range(7) == 0);
                end else if (roll < 80) begin
                    issue(CMD_EDGE, pick_id(base, span), pick_id(base, span),
                          $urandom_range(7) == 0);
                end else begin
                    issue(CMD_READ, pick_index(), ID_W'($urandom), $urandom_range(7) == 0);
                end
            end
        end
    endtask

    task automatic fill_table();
        logic [ID_W-1:0] order [ID_SPACE];
        logic [ID_W-1:0] swap;
        int unsigned     pick;
        for (int i = 0; i < ID_SPACE; i++) begin
            order[i] = ID_W'(i);
        end
        for (int i = ID_SPACE - 1; i > 0; i--) begin
            pick = $urandom_range(i);
            swap = order[i];
            order[i] = order[pick];
            order[pick] = swap;
        end
        no_idle = 1'b1;
        issue(CMD_CLEAR, '0, '0, 1'b0);
        for (int i = 0; i < FILL_ITEMS; i++) begin
            issue(CMD_INSERT, order[i], ID_W'($urandom), $urandom_range(7) == 0);
        end
        issue(CMD_READ, '1, '0, 1'b0);
        issue(CMD_READ, '0, '0, 1'b0);
        issue(CMD_EDGE, order[0], order[FILL_ITEMS-1], 1'b0);
        issue(CMD_INSERT, order[FILL_ITEMS-1], '0, 1'b1);
        no_idle = 1'b0;
        issue(CMD_CLEAR, '1, '1, 1'b1);
    endtask

    task automatic run_directed();
        issue(CMD_READ,   '0,       '0,       1'b0);
        issue(CMD_EDGE,   '0,       '1,       1'b0);
        issue(CMD_INSERT, '1,       '0,       1'b0);
        issue(CMD_INSERT, '0,       '1,       1'b0);
        issue(CMD_INSERT, '1,       '1,       1'b1);
        issue(CMD_INSERT, 12'hAAA,  12'h555,  1'b0);
        issue(CMD_INSERT, 12'h555,  12'hAAA,  1'b0);
        issue(CMD_EDGE,   '1,       '0,       1'b0);
        issue(CMD_EDGE,   12'h555,  12'h123,  1'b0);
        issue(CMD_EDGE,   12'h321,  12'hAAA,  1'b0);
        issue(CMD_READ,   12'd0,    '1,       1'b0);
        issue(CMD_READ,   12'd3,    '0,       1'b0);
        issue(CMD_READ,   12'd4,    '0,       1'b0);
        issue(CMD_READ,   '1,       '0,       1'b1);
        issue(CMD_CLEAR,  '0,       '0,       1'b1);
        issue(CMD_EDGE,   '1,       '0,       1'b0);
        issue(CMD_READ,   '0,       '0,       1'b0);
        issue(CMD_INSERT, 12'h555,  '0,       1'b0);
        issue(CMD_INSERT, '0,       '0,       1'b0);
        issue(CMD_EDGE,   '0,       12'hAAA,  1'b0);
        issue(CMD_EDGE,   12'h555,  '0,       1'b1);
        issue(CMD_CLEAR,  '1,       '1,       1'b0);
    endtask

    initial begin
        int unsigned seg_items;
        int unsigned len;
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        hold_req = 1'b1;
        run_segment(80, $urandom, 32, 0);
        wait (!hold_req);
        wait_for_results();

        fill_table();

        seg_items = 0;
        while (seg_items < 400) begin
            len = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(20, 120);
            run_segment(len, $urandom, $urandom_range(2, 64), 3);
            if ($urandom_range(1) == 1) begin
                issue(CMD_CLEAR, ID_W'($urandom), ID_W'($urandom), $urandom_range(7) == 0);
            end
            seg_items += len;
        end

        // Many clears over a small id pool, enough to wrap the stored epoch tag at least once.
        run_segment(700, $urandom, 16, 45);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("id_compaction_remap_table verification clean");
        end else begin
            $display("id_compaction_remap_table verification failed");
        end
        $finish;
    end

endmodule
